// ===== rtl/sclt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_pkg: shared types and constants of the sector cache tag store
// Command codes, the word broadcast to every slot cell, the search carry that
// ripples along the cell chain, and the write-back request.
// ----------------------------------------------------------------------------
package sclt_pkg;

  // command codes
  localparam logic [1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [1:0] CMD_ADD        = 2'd1;
  localparam logic [1:0] CMD_INVALIDATE = 2'd2;

  // drive number that frees the picked slot, untagged, on add
  localparam logic [7:0] DRIVE_NONE = 8'hFF;

  // command word seen by every cell during a sweep
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  drive;
    logic [31:0] sector;
    logic [31:0] sector_last;
    logic [31:0] counter;
  } bcast_t;

  // search carry handed from cell to cell
  typedef struct packed {
    logic        tok;   // sweep token is here
    logic        hit;   // lookup hit, or free slot found on add
    logic [31:0] age;   // largest age so far on add
  } carry_t;

  // write-back request to the picked slot
  typedef struct packed {
    logic        en;
    logic        valid;
    logic        tag;
    logic        stamp;
    logic [31:0] stamp_val;
  } wr_t;

endpackage

// ===== rtl/sclt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclt_cell: one slot of the tag store
// Holds valid, drive, sector and stamp of one slot. When the sweep token
// arrives it compares its tag against the command, updates the search carry
// and hands it on to the next cell through its carry register.
// ----------------------------------------------------------------------------
module sclt_cell #(
  parameter int IDX    = 0,
  parameter int IDX_W  = 5,
  parameter int CNT_W  = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sclt_pkg::bcast_t       bc,
  input  logic [CNT_W-1:0]       live,
  input  sclt_pkg::carry_t       carry_in,
  input  logic [IDX_W-1:0]       pick_in,
  output sclt_pkg::carry_t       carry_out,
  output logic [IDX_W-1:0]       pick_out,
  input  sclt_pkg::wr_t          wr,
  input  logic [IDX_W-1:0]       wr_idx
);
  import sclt_pkg::*;

  logic        valid;
  logic [7:0]  drive;
  logic [31:0] sector;
  logic [31:0] stamp;

  logic             active;
  logic             tag_match;
  logic             in_range;
  logic             wr_sel;
  logic [31:0]      age;
  carry_t           carry_next;
  logic [IDX_W-1:0] pick_next;
  logic             clear_hit;

  assign active    = CNT_W'(IDX) < live;
  assign tag_match = valid && (drive == bc.drive);
  assign in_range  = (sector >= bc.sector) && (sector <= bc.sector_last);
  assign age       = bc.counter - stamp;
  assign wr_sel    = wr.en && (wr_idx == IDX_W'(IDX));

  // compare against the command and update the carry
  always_comb begin
    carry_next = carry_in;
    pick_next  = pick_in;
    clear_hit  = 1'b0;
    if (carry_in.tok && active) begin
      case (bc.cmd)
        CMD_LOOKUP: begin
          if (!carry_in.hit && tag_match && (sector == bc.sector)) begin
            carry_next.hit = 1'b1;
            pick_next      = IDX_W'(IDX);
          end
        end
        CMD_ADD: begin
          if (!carry_in.hit) begin
            if (!valid) begin
              carry_next.hit = 1'b1;
              pick_next      = IDX_W'(IDX);
            end else if (age > carry_in.age) begin
              carry_next.age = age;
              pick_next      = IDX_W'(IDX);
            end
          end
        end
        CMD_INVALIDATE: begin
          clear_hit = tag_match && in_range;
        end
        default: begin
        end
      endcase
    end
  end

  // carry register towards the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.tok <= 1'b0;
    end else begin
      carry_out.tok <= carry_next.tok;
    end
    carry_out.hit <= carry_next.hit;
    carry_out.age <= carry_next.age;
    pick_out      <= pick_next;
  end

  // slot state: range clear during the sweep, write-back afterwards
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_sel) begin
      valid <= wr.valid;
    end else if (clear_hit) begin
      valid <= 1'b0;
    end
    if (wr_sel && wr.tag) begin
      drive  <= bc.drive;
      sector <= bc.sector;
    end
    if (wr_sel && wr.stamp) begin
      stamp <= wr.stamp_val;
    end
  end

endmodule

// ===== rtl/sector_cache_lru_tags_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_lru_tags_top: tag store of a fully associative sector cache
// Lookup, add with least-recently-used replacement by timestamp, and range
// invalidate, over a chain of slot cells swept by a search token.
// ----------------------------------------------------------------------------
//  channel | handshake           | word
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_ready | command, drive, sector, sector_last
//  out     | out_valid/out_ready | found, slot
//  cfg     | cfg_we              | cfg_wdata (active_slots)
//
//  for each word the search token walks the cell chain one slot per cycle,
//  then the write state loads the result and issues the write-back.
//  reset clears all valid bits, the use counter and active_slots at once.
//  a result held by out_ready low stalls the write-back; no new word is
//  taken until the current result has been loaded.
// ----------------------------------------------------------------------------
module sector_cache_lru_tags_top #(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  drive,
  input  logic [31:0] sector,
  input  logic [31:0] sector_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [4:0]  slot
);
  import sclt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_WRITE} state_t;

  state_t           state;
  logic [5:0]       active_slots;
  logic [31:0]      use_counter;
  bcast_t           bc;
  carry_t           head;
  logic [IDX_W-1:0] head_pick;
  logic             fin_hit;
  logic [IDX_W-1:0] fin_pick;
  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;

  logic [CNT_W-1:0] live;
  logic             in_acc;
  logic             out_free;

  carry_t           chain [NUM_SLOTS+1];
  logic [IDX_W-1:0] chain_pick [NUM_SLOTS+1];

  // slots in use, saturated to the chain length
  assign live = ({26'd0, active_slots} > 32'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                        : CNT_W'(active_slots);

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= 6'd0;
    end else if (cfg_we) begin
      active_slots <= cfg_wdata;
    end
  end

  // cell chain
  assign chain[0]      = head;
  assign chain_pick[0] = head_pick;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    sclt_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .bc        (bc),
      .live      (live),
      .carry_in  (chain[g]),
      .pick_in   (chain_pick[g]),
      .carry_out (chain[g+1]),
      .pick_out  (chain_pick[g+1]),
      .wr        (wr),
      .wr_idx    (wr_idx)
    );
  end

  // sequencer, write-back and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      use_counter <= 32'd0;
      head.tok    <= 1'b0;
      wr.en       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      head.tok <= 1'b0;
      wr.en    <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            bc.cmd         <= command;
            bc.drive       <= drive;
            bc.sector      <= sector;
            bc.sector_last <= sector_last;
            head.tok       <= 1'b1;
            state          <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (chain[NUM_SLOTS].tok) begin
            fin_hit  <= chain[NUM_SLOTS].hit;
            fin_pick <= chain_pick[NUM_SLOTS];
            state    <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            found        <= 1'b0;
            slot         <= 5'd0;
            wr_idx       <= fin_pick;
            wr.stamp_val <= use_counter;
            state        <= S_IDLE;
            case (bc.cmd)
              CMD_LOOKUP: begin
                if (fin_hit) begin
                  found       <= 1'b1;
                  slot        <= 5'(fin_pick);
                  wr.en       <= 1'b1;
                  wr.valid    <= 1'b1;
                  wr.tag      <= 1'b0;
                  wr.stamp    <= 1'b1;
                  use_counter <= use_counter + 32'd1;
                end
              end
              CMD_ADD: begin
                if (live != '0) begin
                  found <= 1'b1;
                  slot  <= 5'(fin_pick);
                  wr.en <= 1'b1;
                  if (bc.drive != DRIVE_NONE) begin
                    wr.valid    <= 1'b1;
                    wr.tag      <= 1'b1;
                    wr.stamp    <= 1'b1;
                    use_counter <= use_counter + 32'd1;
                  end else begin
                    wr.valid <= 1'b0;
                    wr.tag   <= 1'b0;
                    wr.stamp <= 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    bc.counter <= use_counter;
    head.hit   <= 1'b0;
    head.age   <= 32'd0;
    head_pick  <= '0;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sector cache tag store
// Drives lookup, add and range invalidate words through the valid/ready input,
// predicts every result from its own copy of the tag, stamp and counter state
// and compares each returned word in order. The active slot count is rewritten
// between phases, at its extremes too. Sender bursts, receiver stalls and two
// long receiver hold-offs keep the handshakes busy.
// ----------------------------------------------------------------------------
module tb_top;
  import sclt_pkg::*;

  localparam int NUM_SLOTS = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE = 24;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // tag store predictor and the queue of results it still expects
  class sector_tag_scoreboard;
    typedef struct packed {
      logic       found;
      logic [4:0] slot;
    } tag_result_t;

    bit          tag_valid[NUM_SLOTS];
    bit [7:0]    tag_drive[NUM_SLOTS];
    bit [31:0]   tag_sector[NUM_SLOTS];
    bit [31:0]   tag_stamp[NUM_SLOTS];
    bit [31:0]   use_count;
    bit [5:0]    active_slots;
    tag_result_t results_due[$];
    int          failures;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tag_valid[i] = 1'b0;
        tag_drive[i] = '0;
        tag_sector[i] = '0;
        tag_stamp[i] = '0;
      end
      use_count = '0;
      active_slots = '0;
      failures = 0;
    endfunction

    function void set_active(bit [5:0] value);
      active_slots = value;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // work out the result of one accepted word and update the tag state
    function void note_command(logic [1:0] cmd, logic [7:0] drv, logic [31:0] sec,
                               logic [31:0] last);
      int          live;
      int          pick;
      bit [31:0]   best_age;
      bit [31:0]   age;
      tag_result_t res;
      live = (active_slots > NUM_SLOTS) ? NUM_SLOTS : int'(active_slots);
      res = '0;
      case (cmd)
        CMD_LOOKUP: begin
          for (int i = 0; i < live; i++) begin
            if (tag_valid[i] && tag_drive[i] == drv && tag_sector[i] == sec) begin
              tag_stamp[i] = use_count;
              use_count = use_count + 1;
              res.found = 1'b1;
              res.slot = i[4:0];
              break;
            end
          end
        end
        CMD_ADD: begin
          if (live != 0) begin
            best_age = '0;
            pick = 0;
            // first free slot wins, else the oldest, lower slot on a tie
            for (int i = 0; i < live; i++) begin
              if (!tag_valid[i]) begin
                pick = i;
                break;
              end
              age = use_count - tag_stamp[i];
              if (age > best_age) begin
                best_age = age;
                pick = i;
              end
            end
            if (drv != DRIVE_NONE) begin
              tag_valid[pick] = 1'b1;
              tag_drive[pick] = drv;
              tag_sector[pick] = sec;
              tag_stamp[pick] = use_count;
              use_count = use_count + 1;
            end else begin
              tag_valid[pick] = 1'b0;
            end
            res.found = 1'b1;
            res.slot = pick[4:0];
          end
        end
        CMD_INVALIDATE: begin
          for (int i = 0; i < live; i++) begin
            if (tag_valid[i] && tag_drive[i] == drv && tag_sector[i] >= sec &&
                tag_sector[i] <= last)
              tag_valid[i] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      results_due.push_back(res);
    endfunction

    // compare one returned word with the oldest expectation
    function void check_result(logic got_found, logic [4:0] got_slot);
      tag_result_t want;
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word: found=%0d slot=%0d", got_found, got_slot);
        return;
      end
      want = results_due.pop_front();
      if (got_found !== want.found || got_slot !== want.slot) begin
        failures++;
        if (failures <= 10)
          $display("result mismatch: expected found=%0d slot=%0d, got found=%0d slot=%0d",
                   want.found, want.slot, got_found, got_slot);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_LOOKUP;
  logic [7:0]  drive = '0;
  logic [31:0] sector = '0;
  logic [31:0] sector_last = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [4:0]  slot;

  sector_tag_scoreboard sb = new();

  logic [31:0] sector_pool[POOL_SIZE];
  logic [7:0]  drive_pool[3] = '{8'h00, 8'h01, 8'hFE};
  int          phase_slots[12] = '{63, 1, 2, 32, 4, 33, 8, 31, 0, 17, 5, 32};

  int          cycle_count = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  logic [7:0]  stall_pattern = 8'h01;

  sector_cache_lru_tags_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .drive(drive),
    .sector(sector),
    .sector_last(sector_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .slot(slot)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: checks each word taken, stalls on its own pattern
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      sb.check_result(found, slot);
      results_seen++;
      // long hold-off so the block backs up onto its input
      if (results_seen == 250 || results_seen == 1100)
        hold_left = 400;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 80);
      stall_pattern = 8'($urandom);
      if (stall_pattern == 8'h00)
        stall_pattern = 8'h01;
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  // offer one word and wait until it is taken
  task automatic send_word(input logic [1:0] c, input logic [7:0] d, input logic [31:0] s,
                           input logic [31:0] l);
    in_valid <= 1'b1;
    command <= c;
    drive <= d;
    sector <= s;
    sector_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(c, d, s, l);
  endtask

  // let every outstanding word come back, then allow for one more sweep
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 6) @(posedge clk);
  endtask

  task automatic write_active(input logic [5:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_active(value);
    cfg_we <= 1'b0;
  endtask

  // random words, mostly drawn from small tag pools so lookups hit
  task automatic run_random(input int count);
    int          burst_left;
    int          roll;
    logic [1:0]  c;
    logic [7:0]  d;
    logic [31:0] s;
    logic [31:0] l;
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)
        c = CMD_LOOKUP;
      else if (roll < 80)
        c = CMD_ADD;
      else if (roll < 95)
        c = CMD_INVALIDATE;
      else
        c = CMD_UNUSED;
      if ($urandom_range(0, 99) < 88)
        d = drive_pool[$urandom_range(0, 2)];
      else
        d = 8'($urandom);
      if (c == CMD_ADD && $urandom_range(0, 15) == 0)
        d = DRIVE_NONE;
      if ($urandom_range(0, 99) < 88)
        s = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        s = $urandom;
      l = $urandom;
      if (c == CMD_INVALIDATE) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          s = s - $urandom_range(0, 4);
          l = s + $urandom_range(0, 40);
        end else if (roll < 85) begin
          l = s - $urandom_range(1, 8);
        end else if (roll < 92) begin
          s = '0;
          l = '1;
        end
      end
      send_word(c, d, s, l);
      burst_left--;
      if (i == count - 1) begin
        in_valid <= 1'b0;
      end else if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        // now and then a long burst with no gaps at all
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
      end
    end
  endtask

  // main sequence
  initial begin
    sector_pool[0] = '0;
    sector_pool[1] = '1;
    sector_pool[2] = $urandom;
    for (int i = 3; i < POOL_SIZE; i++)
      sector_pool[i] = sector_pool[2] + 3 * i;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // no active slots: nothing hits, add fails
    write_active(6'd0);
    send_word(CMD_LOOKUP, 8'h00, 32'h0, 32'h0);
    send_word(CMD_ADD, 8'h00, 32'h0, 32'h0);
    send_word(CMD_INVALIDATE, 8'h00, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_UNUSED, 8'h00, 32'h0, 32'h0);
    in_valid <= 1'b0;
    wait_idle();

    // count above the slot total saturates; tag extremes, duplicates, ranges
    write_active(6'd63);
    send_word(CMD_ADD, 8'h00, 32'h0, 32'h0);
    send_word(CMD_ADD, 8'hFE, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_ADD, DRIVE_NONE, 32'h5, 32'h0);
    send_word(CMD_ADD, 8'h00, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, 8'h00, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 8'hFE, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_LOOKUP, DRIVE_NONE, 32'h5, 32'h0);
    send_word(CMD_INVALIDATE, 8'h00, 32'h1, 32'h0);
    send_word(CMD_LOOKUP, 8'h00, 32'h0, 32'h0);
    send_word(CMD_INVALIDATE, 8'h00, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, 8'h00, 32'h0, 32'h0);
    send_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_ADD, 8'h5A, 32'h8000_0001, 32'h0);
    in_valid <= 1'b0;
    wait_idle();

    // random phases over a spread of active slot counts
    foreach (phase_slots[p]) begin
      write_active(phase_slots[p][5:0]);
      run_random(162);
      wait_idle();
    end

    if (sb.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
